// File: hw/rtl/tkaps_pkg.sv
// ----------------------------------------------------------------------------
// tkaps_pkg: shared types and constants for the top-K product select block
// Payload words, queue entry layout, queue sizing and back-end state codes.
// ----------------------------------------------------------------------------
package tkaps_pkg;

	localparam int UNIT_W  = 10;
	localparam int MAG_W   = 31;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	typedef struct packed {
		logic signed [15:0] activation;
		logic signed [15:0] weight;
		logic               last_item;
	} item_t;

	typedef struct packed {
		logic                     slot_valid;
		logic        [UNIT_W-1:0] unit_index;
		logic signed [15:0]       kept_activation;
		logic signed [15:0]       kept_weight;
		logic signed [31:0]       product;
		logic                     end_of_run;
	} result_t;

	// one ranked entry as held in the table
	typedef struct packed {
		logic        [UNIT_W-1:0] unit;
		logic signed [15:0]       act;
		logic signed [15:0]       wgt;
		logic signed [31:0]       prod;
		logic        [MAG_W-1:0]  mag;
	} slot_t;

	// queue word between front and back
	typedef struct packed {
		slot_t slot;
		logic  last;
	} entry_t;

	typedef enum logic {
		ST_INSERT,
		ST_EMIT
	} back_state_t;

endpackage

// File: hw/rtl/top_k_abs_product_select_core.sv
// ----------------------------------------------------------------------------
// top_k_abs_product_select_core: streaming top-K by product magnitude
// Throughput: one word per cycle unless item_stall is high. After a last word
// the table emits its TOP_K ranks through the output register, one per cycle
// unless result_stall is high; the 4-entry queue lets input run on meanwhile.
// Reset: asynchronous, clears table marks, run count, queue and handshakes.
// ----------------------------------------------------------------------------
module top_k_abs_product_select_core #(
	parameter int TOP_K      = 8,
	parameter int MAX_HIDDEN = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  tkaps_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output tkaps_pkg::result_t result
);

	logic              push;
	tkaps_pkg::entry_t push_entry;
	logic              q_full;
	logic              pop;
	tkaps_pkg::entry_t q_head;
	logic              q_empty;

	tkaps_front #(
		.MAX_HIDDEN (MAX_HIDDEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	tkaps_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	tkaps_back #(
		.TOP_K (TOP_K)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: hw/rtl/tkaps_front.sv
// ----------------------------------------------------------------------------
// tkaps_front: input stage
// Numbers each word within its run, forms the product and its magnitude and
// hands the classified entry to the queue.
// ----------------------------------------------------------------------------
module tkaps_front #(
	parameter int MAX_HIDDEN = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  tkaps_pkg::item_t        item,
	output logic                    push,
	output tkaps_pkg::entry_t       push_entry,
	input  logic                    q_full
);

	localparam int CNT_W = $clog2(MAX_HIDDEN);

	logic                           accept;
	logic [CNT_W-1:0]               cnt_q;
	logic [CNT_W+tkaps_pkg::UNIT_W-1:0] cnt_ext;

	logic                           valid_s1;
	logic                           last_s1;
	logic [tkaps_pkg::UNIT_W-1:0]   unit_s1;
	logic signed [15:0]             act_s1;
	logic signed [15:0]             wgt_s1;
	logic signed [31:0]             prod_s1;
	logic [31:0]                    neg_prod;

	assign item_stall = valid_s1 && q_full;
	assign accept     = item_valid && !item_stall;
	assign push       = valid_s1 && !q_full;

	// index is the count folded to the unit field width
	assign cnt_ext = {{tkaps_pkg::UNIT_W{1'b0}}, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (item.last_item) begin
				cnt_q <= '0;
			end else if (cnt_q != CNT_W'(MAX_HIDDEN - 1)) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= item.last_item;
			unit_s1 <= cnt_ext[tkaps_pkg::UNIT_W-1:0];
			act_s1  <= item.activation;
			wgt_s1  <= item.weight;
			prod_s1 <= item.activation * item.weight;
		end
	end

	// Q9.22 magnitude fits 31 bits, the most negative product cannot occur
	assign neg_prod = 32'd0 - prod_s1;

	always_comb begin
		push_entry.last      = last_s1;
		push_entry.slot.unit = unit_s1;
		push_entry.slot.act  = act_s1;
		push_entry.slot.wgt  = wgt_s1;
		push_entry.slot.prod = prod_s1;
		push_entry.slot.mag  = prod_s1[31] ? neg_prod[tkaps_pkg::MAG_W-1:0]
		                                   : prod_s1[tkaps_pkg::MAG_W-1:0];
	end

endmodule

// File: hw/rtl/tkaps_fifo.sv
// ----------------------------------------------------------------------------
// tkaps_fifo: short queue between front and back
// Register-based FIFO with a single read port at the head.
// ----------------------------------------------------------------------------
module tkaps_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tkaps_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output tkaps_pkg::entry_t head,
	output logic              empty
);

	tkaps_pkg::entry_t              mem_q [tkaps_pkg::Q_DEPTH];
	logic [tkaps_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [tkaps_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [tkaps_pkg::Q_CNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == tkaps_pkg::Q_CNT_W'(tkaps_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// File: hw/rtl/tkaps_back.sv
// ----------------------------------------------------------------------------
// tkaps_back: ranking table and result output
// Chain of cells compares every kept magnitude with the incoming entry in
// parallel and shifts the losers down a rank. On the last word of a run the
// chain is shifted out through the output register, which empties it.
// ----------------------------------------------------------------------------
module tkaps_back #(
	parameter int TOP_K = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  tkaps_pkg::entry_t    q_head,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output tkaps_pkg::result_t   result
);

	localparam int EMIT_W = $clog2(TOP_K + 1);

	tkaps_pkg::back_state_t state_q, state_d;

	logic                 used_q [TOP_K];
	tkaps_pkg::slot_t     cell_q [TOP_K];
	logic [TOP_K-1:0]     win;
	logic                 ins_used [TOP_K];
	tkaps_pkg::slot_t     ins_cell [TOP_K];
	logic                 sh_used  [TOP_K];
	tkaps_pkg::slot_t     sh_cell  [TOP_K];

	logic [EMIT_W-1:0]    emit_cnt_q;
	logic                 out_free;
	logic                 emit_go;
	logic                 emit_end;
	logic                 res_valid_q;
	tkaps_pkg::result_t   res_q;

	assign out_free = !res_valid_q || !result_stall;
	assign emit_end = (emit_cnt_q == EMIT_W'(TOP_K - 1));

	// an empty cell loses to anything; ties keep the older entry ahead
	always_comb begin
		for (int i = 0; i < TOP_K; i++) begin
			win[i] = !used_q[i] || (q_head.slot.mag > cell_q[i].mag);
		end
	end

	for (genvar i = 0; i < TOP_K; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign ins_used[i] = 1'b1;
			assign ins_cell[i] = q_head.slot;
		end else begin : g_body
			assign ins_used[i] = win[i-1] ? used_q[i-1] : 1'b1;
			assign ins_cell[i] = win[i-1] ? cell_q[i-1] : q_head.slot;
		end
		if (i == TOP_K - 1) begin : g_tail
			assign sh_used[i] = 1'b0;
			assign sh_cell[i] = cell_q[i];
		end else begin : g_mid
			assign sh_used[i] = used_q[i+1];
			assign sh_cell[i] = cell_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkaps_pkg::ST_INSERT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit_go = 1'b0;
		unique case (state_q)
			tkaps_pkg::ST_INSERT: begin
				pop = !q_empty;
				if (pop && q_head.last) begin
					state_d = tkaps_pkg::ST_EMIT;
				end
			end
			tkaps_pkg::ST_EMIT: begin
				emit_go = out_free;
				if (emit_go && emit_end) begin
					state_d = tkaps_pkg::ST_INSERT;
				end
			end
			default: begin
				state_d = tkaps_pkg::ST_INSERT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOP_K; i++) begin
				used_q[i] <= 1'b0;
			end
			emit_cnt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			for (int i = 0; i < TOP_K; i++) begin
				if (pop && win[i]) begin
					used_q[i] <= ins_used[i];
				end else if (emit_go) begin
					used_q[i] <= sh_used[i];
				end
			end
			if (emit_go) begin
				emit_cnt_q <= emit_end ? '0 : emit_cnt_q + 1'b1;
			end
			if (out_free) begin
				res_valid_q <= emit_go;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < TOP_K; i++) begin
			if (pop && win[i]) begin
				cell_q[i] <= ins_cell[i];
			end else if (emit_go) begin
				cell_q[i] <= sh_cell[i];
			end
		end
		if (emit_go) begin
			res_q.slot_valid      <= used_q[0];
			res_q.unit_index      <= used_q[0] ? cell_q[0].unit : '0;
			res_q.kept_activation <= used_q[0] ? cell_q[0].act  : '0;
			res_q.kept_weight     <= used_q[0] ? cell_q[0].wgt  : '0;
			res_q.product         <= used_q[0] ? cell_q[0].prod : '0;
			res_q.end_of_run      <= emit_end;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
